// File: rtl/fpa_pkg.sv
// Shared types and codes for the fixed partition allocator.
package fpa_pkg;

    // Operation codes carried in the input tuser field.
    localparam logic [1:0] MODE_LOAD     = 2'd0;
    localparam logic [1:0] MODE_FREE_ALL = 2'd1;
    localparam logic [1:0] MODE_ALLOC    = 2'd2;

    // Placement policies; the unused code behaves as first fit.
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_FIT_POLICY      = 1'b0;
    localparam logic CFG_PARTITION_COUNT = 1'b1;

    // Fixed field widths of the stream payloads and configuration registers.
    localparam int MODE_W   = 2;
    localparam int PIDX_W   = 3;
    localparam int REQ_W    = 16;
    localparam int RID_W    = 8;
    localparam int CHOSEN_W = 3;
    localparam int LEFT_W   = 16;
    localparam int POL_W    = 2;
    localparam int COUNT_W  = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic latch;       // capture the accepted transaction
        logic apply;       // perform a load or free-all update
        logic scan_start;  // restart the read pointer at partition zero
        logic scan_step;   // read the next partition capacity
        logic finish;      // commit the grant and load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic is_alloc;    // captured transaction is an allocation
        logic limit_zero;  // no partition is scanned
        logic scan_last;   // the read pointer sits on the last scanned partition
        logic out_free;    // result register can take a new result
    } t_dp_status;

endpackage

// File: rtl/fpa_ram.sv
// Generic single-port-write, registered-read RAM.
module fpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/fpa_ctrl.sv
// Controller state machine that sequences one transaction at a time.
module fpa_ctrl
    import fpa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.is_alloc && !i_status.limit_zero) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.apply      = 1'b1;
                o_cmd.scan_start = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_FINISH: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/fpa_datapath.sv
// Datapath: partition table, a scan that checks one partition at a time and the result register.
module fpa_datapath
    import fpa_pkg::*;
#(
    parameter int PARTITIONS = 8,
    parameter int SIZE_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [PIDX_W-1:0]   i_partition_index,
    input  logic [REQ_W-1:0]    i_size,
    input  logic [POL_W-1:0]    i_fit_policy,
    input  logic [COUNT_W-1:0]  i_partition_count,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_granted,
    output logic [CHOSEN_W-1:0] o_chosen_partition,
    output logic [LEFT_W-1:0]   o_leftover_space
);

    localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

    logic [MODE_W-1:0]    r_mode;
    logic [PIDX_W-1:0]    r_pidx;
    logic [SIZE_BITS-1:0] r_size;
    logic [PARTITIONS-1:0] r_in_use;
    logic [IDX_W-1:0]     r_rd_idx;
    logic                 r_ev_valid;
    logic [IDX_W-1:0]     r_ev_idx;
    logic                 r_found;
    logic [IDX_W-1:0]     r_pick;
    logic [SIZE_BITS-1:0] r_best;
    logic                 r_out_valid;
    logic                 r_out_granted;
    logic [CHOSEN_W-1:0]  r_out_chosen;
    logic [LEFT_W-1:0]    r_out_left;

    logic [31:0]          w_size_ext;
    logic [31:0]          w_limit;
    logic                 w_pidx_ok;
    logic [IDX_W-1:0]     w_widx;
    logic                 w_load_we;
    logic [SIZE_BITS-1:0] w_rdata;
    logic                 w_cand;
    logic                 w_take;
    logic [SIZE_BITS-1:0] w_diff;
    logic [31:0]          w_diff_ext;
    logic [31:0]          w_pick_ext;

    assign w_size_ext = 32'(i_size);
    // Counts beyond the table size scan the whole table.
    assign w_limit    = (32'(i_partition_count) > PARTITIONS) ? PARTITIONS
                                                              : 32'(i_partition_count);
    assign w_pidx_ok  = 32'(r_pidx) < PARTITIONS;
    assign w_widx     = IDX_W'(r_pidx);
    assign w_load_we  = i_cmd.apply && (r_mode == MODE_LOAD) && w_pidx_ok;

    fpa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (PARTITIONS)
    ) u_cap_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (w_widx),
        .i_wdata (r_size),
        .i_raddr (r_rd_idx),
        .o_rdata (w_rdata)
    );

    // A candidate is free and large enough; ties keep the earlier pick.
    assign w_cand = r_ev_valid && !r_in_use[r_ev_idx] && (w_rdata >= r_size);
    assign w_take = w_cand && (!r_found
                    || ((i_fit_policy == POL_BEST)  && (w_rdata < r_best))
                    || ((i_fit_policy == POL_WORST) && (w_rdata > r_best)));

    assign w_diff     = r_best - r_size;
    assign w_diff_ext = 32'(w_diff);
    assign w_pick_ext = 32'(r_pick);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_mode;
            r_pidx <= i_partition_index;
            r_size <= w_size_ext[SIZE_BITS-1:0];
        end
        if (i_cmd.scan_start) begin
            r_rd_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        r_ev_idx <= r_rd_idx;
        if (w_take) begin
            r_pick <= r_ev_idx;
            r_best <= w_rdata;
        end
        if (i_cmd.finish) begin
            r_out_granted <= r_found;
            r_out_chosen  <= r_found ? w_pick_ext[CHOSEN_W-1:0] : '0;
            r_out_left    <= r_found ? w_diff_ext[LEFT_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use    <= '0;
            r_ev_valid  <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ev_valid <= i_cmd.scan_step;
            if (i_cmd.latch) begin
                r_found <= 1'b0;
            end else if (w_take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.apply && (r_mode == MODE_FREE_ALL)) begin
                r_in_use <= '0;
            end else if (w_load_we) begin
                r_in_use[w_widx] <= 1'b0;
            end else if (i_cmd.finish && r_found) begin
                r_in_use[r_pick] <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.is_alloc   = (r_mode == MODE_ALLOC);
    assign o_status.limit_zero = (w_limit == 32'd0);
    assign o_status.scan_last  = ((32'(r_rd_idx) + 32'd1) == w_limit);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_granted          = r_out_granted;
    assign o_chosen_partition = r_out_chosen;
    assign o_leftover_space   = r_out_left;

endmodule

// File: rtl/fixed_partition_allocator_unit.sv
// A transaction that does not scan passes the execute and finish states after acceptance; an
// allocation reads one capacity per cycle over N partitions, then drains before it finishes.
// The next transaction is accepted only after the previous one has finished, which is
// delayed while the sink stalls a result.
// Reset (synchronous, active low) frees every partition and sets first fit with 8 partitions;
// partition capacities are not cleared and must be loaded before they are allocated.
module fixed_partition_allocator_unit
    import fpa_pkg::*;
#(
    parameter int PARTITIONS = 8,
    parameter int SIZE_BITS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port: index 0 is fit_policy, index 1 is partition_count.
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [3:0]   i_cfg_wdata,
    // Input stream.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // [2:0] partition_index, [18:3] size,
                                        // [26:19] request_id, [31:27] zero
    input  logic [1:0]   s_axis_tuser,  // [1:0] mode
    // Result stream.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,  // [2:0] chosen_partition, [18:3] leftover_space,
                                        // [23:19] zero
    output logic [0:0]   m_axis_tuser   // [0] granted
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    logic [POL_W-1:0]    r_fit_policy;
    logic [COUNT_W-1:0]  r_partition_count;
    logic                w_granted;
    logic [CHOSEN_W-1:0] w_chosen;
    logic [LEFT_W-1:0]   w_left;

    // Configuration registers. Writes must happen only while the block is idle; the block
    // does not enforce this, and the datapath reads them directly without a shadow copy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy      <= POL_FIRST;
            r_partition_count <= 4'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FIT_POLICY: begin
                    r_fit_policy <= i_cfg_wdata[POL_W-1:0];
                end
                CFG_PARTITION_COUNT: begin
                    r_partition_count <= i_cfg_wdata[COUNT_W-1:0];
                end
                default: begin
                    r_fit_policy <= r_fit_policy;
                end
            endcase
        end
    end

    // The controller decides when each step runs; the datapath does the work and
    // reports back whether the item allocates and where the scan stands.
    fpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The result register sits in the datapath, so a finished result can wait
    // for the sink while the next transaction is already accepted and scanned.
    fpa_datapath #(
        .PARTITIONS (PARTITIONS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_mode             (s_axis_tuser),
        .i_partition_index  (s_axis_tdata[2:0]),
        .i_size             (s_axis_tdata[18:3]),
        .i_fit_policy       (r_fit_policy),
        .i_partition_count  (r_partition_count),
        .o_out_valid        (m_axis_tvalid),
        .i_out_ready        (m_axis_tready),
        .o_granted          (w_granted),
        .o_chosen_partition (w_chosen),
        .o_leftover_space   (w_left)
    );

    // The request owner id is accepted with the transaction but never read back,
    // so it has no effect on any result.
    assign m_axis_tdata = {5'd0, w_left, w_chosen};
    assign m_axis_tuser = w_granted;

    // A granted partition always lies inside the scanned range.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            ((32'(m_axis_tdata[2:0]) < 32'(r_partition_count))
             && (32'(m_axis_tdata[2:0]) < PARTITIONS)))
        else $error("granted partition outside the scanned range");

    // A result without a grant carries all-zero fields.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 24'd0))
        else $error("denied result carries nonzero fields");

    // After accepting a transaction the block is busy for at least the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a transaction is in progress");

    // A result is only produced after the controller finished a transaction.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.finish))
        else $error("result appeared without a finishing step");

endmodule

// File: test/tb_fixed_partition_allocator_unit.sv
// Self-checking testbench for the fixed partition allocator unit.
`timescale 1ns / 1ps

module tb_fixed_partition_allocator_unit
    import fpa_pkg::*;
();

    // Item code that leaves the table untouched, and the spare policy code.
    localparam logic [1:0] MODE_NOP  = 2'd3;
    localparam logic [1:0] POL_SPARE = 2'd3;
    localparam int         NPART     = 8;
    localparam int         SETTLE    = 4;

    typedef struct packed {
        logic        granted;
        logic [2:0]  chosen;
        logic [15:0] leftover;
    } t_grant;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [3:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [2:0] partition_index, [18:3] size, [26:19] request_id
    logic [1:0]  s_axis_tuser;   // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [2:0] chosen_partition, [18:3] leftover_space
    logic [0:0]  m_axis_tuser;   // [0] granted

    fixed_partition_allocator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow copy of the partition table and the two registers.
    logic [15:0] part_cap   [NPART];
    logic        part_busy  [NPART];
    logic [15:0] part_held  [NPART];
    logic [7:0]  part_owner [NPART];
    logic [1:0]  fit_policy_q;
    logic [3:0]  part_count_q;

    t_grant expected_grants[$];

    int error_count;
    int items_sent;
    int grant_count;
    int denial_count;
    int send_gap_pct;
    int recv_stall_pct;
    int hold_cycles;

    // Clock with a 12 ns period.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Applies one transaction to the shadow table and returns the result that the
    // unit must give for it. First fit keeps the first hit; best and worst fit
    // replace the pick only on a strictly better capacity, so ties stay low.
    function automatic t_grant predict_grant(input logic [1:0] mode, input logic [2:0] pidx,
                                             input logic [15:0] size, input logic [7:0] rid);
        t_grant r;
        int     limit;
        bit     found;
        int     pick;
        r     = '0;
        found = 1'b0;
        pick  = 0;
        case (mode)
            MODE_LOAD: begin
                part_cap[pidx]   = size;
                part_busy[pidx]  = 1'b0;
                part_held[pidx]  = '0;
                part_owner[pidx] = '0;
            end
            MODE_FREE_ALL: begin
                for (int k = 0; k < NPART; k++) begin
                    part_busy[k]  = 1'b0;
                    part_held[k]  = '0;
                    part_owner[k] = '0;
                end
            end
            MODE_ALLOC: begin
                // A count above the table size scans the whole table.
                limit = (part_count_q > NPART) ? NPART : int'(part_count_q);
                for (int k = 0; k < limit; k++) begin
                    if (!part_busy[k] && part_cap[k] >= size) begin
                        if (!found) begin
                            found = 1'b1;
                            pick  = k;
                        end else if (fit_policy_q == POL_BEST && part_cap[k] < part_cap[pick]) begin
                            pick = k;
                        end else if (fit_policy_q == POL_WORST && part_cap[k] > part_cap[pick]) begin
                            pick = k;
                        end
                    end
                end
                if (found) begin
                    part_busy[pick]  = 1'b1;
                    part_held[pick]  = size;
                    part_owner[pick] = rid;
                    r.granted  = 1'b1;
                    r.chosen   = pick[2:0];
                    r.leftover = part_cap[pick] - size;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Receiver: random stalls, or a long hold-off counted down here.
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles    = hold_cycles - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Result checker: every result transaction is matched against the oldest
    // outstanding prediction, field by field.
    always @(posedge i_clk) begin
        t_grant exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_grants.size() == 0) begin
                $error("unexpected result transaction: granted %0d, chosen %0d, leftover %0d",
                       m_axis_tuser[0], m_axis_tdata[2:0], m_axis_tdata[18:3]);
                error_count++;
            end else begin
                exp_r = expected_grants.pop_front();
                if (m_axis_tuser[0] !== exp_r.granted) begin
                    $error("granted: expected %0d, got %0d", exp_r.granted, m_axis_tuser[0]);
                    error_count++;
                end
                if (m_axis_tdata[2:0] !== exp_r.chosen) begin
                    $error("chosen_partition: expected %0d, got %0d",
                           exp_r.chosen, m_axis_tdata[2:0]);
                    error_count++;
                end
                if (m_axis_tdata[18:3] !== exp_r.leftover) begin
                    $error("leftover_space: expected %0d, got %0d",
                           exp_r.leftover, m_axis_tdata[18:3]);
                    error_count++;
                end
                if (exp_r.granted) grant_count++;
                else denial_count++;
            end
        end
    end

    // Offers one transaction, with a random gap in front of it, and records the
    // prediction once the unit accepts it. Valid stays high afterwards so that
    // back-to-back transactions are offered without a gap.
    task automatic send_item(input logic [1:0] mode, input logic [2:0] pidx,
                             input logic [15:0] size, input logic [7:0] rid);
        t_grant pred;
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, rid, size, pidx};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = predict_grant(mode, pidx, size, rid);
        expected_grants.insert(expected_grants.size(), pred);
        items_sent++;
    endtask

    // Stops offering and waits until every outstanding result has arrived.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_grants.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Register writes happen only with the unit idle.
    task automatic write_cfg(input logic addr, input logic [3:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == CFG_FIT_POLICY) fit_policy_q = value[1:0];
        else part_count_q = value;
    endtask

    // Every capacity is written before any allocation can scan it, and never
    // forgotten afterwards since reset is not applied again. Equal capacities
    // at both ends of the table and in pairs between them give the tie cases.
    task automatic test_load_table();
        send_item(MODE_LOAD, 3'd0, 16'hFFFF, 8'hFF);
        send_item(MODE_LOAD, 3'd1, 16'd0, 8'h00);
        send_item(MODE_LOAD, 3'd2, 16'd500, 8'h5A);
        send_item(MODE_LOAD, 3'd3, 16'd100, 8'hA5);
        send_item(MODE_LOAD, 3'd4, 16'd500, 8'h00);
        send_item(MODE_LOAD, 3'd5, 16'd100, 8'hFF);
        send_item(MODE_LOAD, 3'd6, 16'd300, 8'h0F);
        send_item(MODE_LOAD, 3'd7, 16'hFFFF, 8'hF0);
    endtask

    // Zero request, full-size request, exhaustion, the no-op code and a free-all.
    task automatic test_first_fit();
        send_item(MODE_ALLOC, 3'd7, 16'd0, 8'hFF);
        send_item(MODE_ALLOC, 3'd0, 16'hFFFF, 8'h00);
        send_item(MODE_ALLOC, 3'd5, 16'hFFFF, 8'h81);
        send_item(MODE_NOP, 3'd7, 16'hFFFF, 8'hFF);
        send_item(MODE_FREE_ALL, 3'd2, 16'h1234, 8'h3C);
    endtask

    // Equal capacities resolve to the lower index; a zero request takes the
    // zero-capacity partition.
    task automatic test_best_fit();
        write_cfg(CFG_FIT_POLICY, {2'b00, POL_BEST});
        send_item(MODE_ALLOC, 3'd0, 16'd100, 8'h11);
        send_item(MODE_ALLOC, 3'd0, 16'd100, 8'h22);
        send_item(MODE_ALLOC, 3'd0, 16'd1, 8'h33);
        send_item(MODE_ALLOC, 3'd0, 16'd0, 8'h44);
    endtask

    task automatic test_worst_fit();
        write_cfg(CFG_FIT_POLICY, {2'b00, POL_WORST});
        send_item(MODE_FREE_ALL, 3'd0, 16'd0, 8'h00);
        send_item(MODE_ALLOC, 3'd0, 16'd7, 8'h55);
        send_item(MODE_ALLOC, 3'd0, 16'd7, 8'h66);
        send_item(MODE_ALLOC, 3'd0, 16'd7, 8'h77);
    endtask

    // Spare policy code, a zero count, an oversized count and a count of one.
    task automatic test_policy_and_count_edges();
        write_cfg(CFG_FIT_POLICY, {2'b00, POL_SPARE});
        write_cfg(CFG_PARTITION_COUNT, 4'd0);
        send_item(MODE_FREE_ALL, 3'd0, 16'd0, 8'h00);
        send_item(MODE_ALLOC, 3'd0, 16'd0, 8'h01);
        write_cfg(CFG_PARTITION_COUNT, 4'd15);
        send_item(MODE_ALLOC, 3'd0, 16'd200, 8'h02);
        write_cfg(CFG_PARTITION_COUNT, 4'd1);
        send_item(MODE_ALLOC, 3'd0, 16'd200, 8'h03);
        write_cfg(CFG_PARTITION_COUNT, 4'd8);
        write_cfg(CFG_FIT_POLICY, {2'b00, POL_FIRST});
    endtask

    // Picks a capacity that often repeats one already in the table, so that
    // best and worst fit meet ties, or sits at an extreme.
    function automatic logic [15:0] pick_capacity();
        case ($urandom_range(3))
            0: return part_cap[$urandom_range(NPART - 1)];
            1: return 16'($urandom_range(65535));
            2: return 16'($urandom_range(600));
            default: return $urandom_range(1) ? 16'hFFFF : 16'd0;
        endcase
    endfunction

    // Requests often aim just under a capacity in the table, so the policies differ; some
    // match one exactly, some land just above one, some are zero or arbitrary.
    function automatic logic [15:0] pick_request();
        logic [15:0] c;
        int          d;
        c = part_cap[$urandom_range(NPART - 1)];
        d = $urandom_range(40);
        case ($urandom_range(5))
            0, 1: return (c > d) ? c - 16'(d) : 16'd0;
            2:    return c;
            3:    return (c != 16'hFFFF) ? c + 16'd1 : c;
            4:    return 16'($urandom_range(65535)) >> $urandom_range(15);
            default: return 16'd0;
        endcase
    endfunction

    // Random traffic: mostly allocations against loaded partitions, with loads
    // and releases often enough that the table keeps turning over, plus no-ops.
    task automatic test_random_traffic(input int n_items);
        int r;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < 58)
                send_item(MODE_ALLOC, 3'($urandom_range(7)), pick_request(),
                          8'($urandom_range(255)));
            else if (r < 78)
                send_item(MODE_LOAD, 3'($urandom_range(7)), pick_capacity(),
                          8'($urandom_range(255)));
            else if (r < 90)
                send_item(MODE_FREE_ALL, 3'($urandom_range(7)), 16'($urandom_range(65535)),
                          8'($urandom_range(255)));
            else if (r < 95)
                send_item(MODE_NOP, 3'($urandom_range(7)), 16'($urandom_range(65535)),
                          8'($urandom_range(255)));
            else
                send_item(MODE_ALLOC, 3'($urandom_range(7)), 16'($urandom_range(65535)),
                          8'($urandom_range(255)));
        end
    endtask

    // Mostly partial and full tables; now and then a zero or oversized count.
    task automatic write_random_cfg();
        int r;
        r = $urandom_range(9);
        write_cfg(CFG_FIT_POLICY, 4'($urandom_range(3)));
        if (r == 0) write_cfg(CFG_PARTITION_COUNT, 4'd0);
        else if (r == 1) write_cfg(CFG_PARTITION_COUNT, 4'($urandom_range(15, 9)));
        else write_cfg(CFG_PARTITION_COUNT, 4'($urandom_range(8, 1)));
    endtask

    // One idling profile: blocks of random traffic under changing settings.
    task automatic test_random_phase(input int gap_pct, input int stall_pct);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        for (int b = 0; b < 7; b++) begin
            write_random_cfg();
            test_random_traffic(50);
        end
    endtask

    // The receiver holds off while the sender keeps offering, so the unit
    // fills and stalls its input; then the sender pauses until all results
    // have drained before traffic resumes.
    task automatic test_backpressure();
        write_cfg(CFG_FIT_POLICY, {2'b00, POL_BEST});
        write_cfg(CFG_PARTITION_COUNT, 4'd8);
        send_gap_pct = 0;
        hold_cycles  = 120;
        test_random_traffic(14);
        wait_idle();
        test_random_traffic(10);
    endtask

    initial begin
        error_count    = 0;
        items_sent     = 0;
        grant_count    = 0;
        denial_count   = 0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        fit_policy_q   = POL_FIRST;
        part_count_q   = 4'd8;
        for (int k = 0; k < NPART; k++) begin
            part_cap[k]   = '0;
            part_busy[k]  = 1'b0;
            part_held[k]  = '0;
            part_owner[k] = '0;
        end
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_load_table();
        test_first_fit();
        test_best_fit();
        test_worst_fit();
        test_policy_and_count_edges();
        test_random_phase(7, 59);
        test_random_phase(59, 7);
        test_backpressure();
        test_random_phase(0, 0);

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d transactions: %0d allocations granted, %0d other results.",
                 items_sent, grant_count, denial_count);
        $display("Covered all item codes, all four policy codes and counts from 0 to 15.");
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
